// File: hw/rtl/pdt_pkg.sv
// Shared constants, command and state types for the pulse time difference core.
// Depends on nothing; imported by every other file of the block.
package pdt_pkg;

  localparam int RECORD_LEN   = 8 * 1024;
  localparam int BASELINE_LEN = 100;
  localparam int SAMPLE_BITS  = 14;
  localparam int THR_W        = 14;
  localparam int THR_RESET    = 1200;
  localparam int TIME_W       = 15;
  localparam int TICK_SHIFT   = 2;

  localparam int IDX_W  = $clog2(RECORD_LEN);
  localparam int BL_AW  = (BASELINE_LEN > 1) ? $clog2(BASELINE_LEN) : 1;
  localparam int PTR_W  = $clog2(BASELINE_LEN + 1);
  localparam int SUM_W  = $clog2(BASELINE_LEN) + SAMPLE_BITS;
  localparam int ADD_W  = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 1;
  localparam int PROD_W = $clog2(BASELINE_LEN) + ADD_W;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef enum logic {
    CMD_EARLY,
    CMD_LIVE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e              kind;
    logic                   scan;
    logic                   last;
    logic [IDX_W-1:0]       idx;
    logic [SAMPLE_BITS-1:0] smp_a;
    logic [SAMPLE_BITS-1:0] smp_b;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_SCAN,
    BK_EMIT
  } back_state_e;

  function automatic logic crosses(logic [SUM_W-1:0] sum, logic [SAMPLE_BITS-1:0] smp,
                                   logic [THR_W-1:0] thr);
    logic [ADD_W-1:0]  level;
    logic [PROD_W-1:0] bound;
    level = ADD_W'(smp) + ADD_W'(thr);
    bound = PROD_W'(BASELINE_LEN) * PROD_W'(level);
    return PROD_W'(sum) > bound;
  endfunction

  function automatic logic [TIME_W-1:0] to_time(logic [IDX_W-1:0] idx);
    return TIME_W'({idx, {TICK_SHIFT{1'b0}}});
  endfunction

endpackage

// File: hw/rtl/dual_channel_pulse_time_difference_core.sv
// Top level of the dual channel pulse time difference core.
// Depends on pdt_pkg, pdt_front, pdt_fifo and pdt_back.
//
//  channel  | direction | content
//  s_axis   | in        | tdata: sample_a[13:0], sample_b[27:14]
//  m_axis   | out       | tdata: time_a, time_b, time_diff; tuser: found_a, found_b
//  cfg      | in        | threshold, one write per enabled cycle
//
// One sample pair is accepted per cycle while the four entry queue has room.
// When the baseline completes the back end scans the 99 buffered pairs through the
// early store read port; the queue fills and input stalls.
// Each record ends in BK_EMIT, where the back end registers its result.
// Reset is immediate: no clearing pass. A result still waiting at the next record end
// holds the back end; the queue then fills and input stalls.
module dual_channel_pulse_time_difference_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pdt_pkg::THR_W-1:0]      cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [pdt_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // sample_a, sample_b
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [pdt_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // time_a, time_b, time_diff
  output logic [pdt_pkg::OUT_USER_W-1:0] m_axis_tuser   // found_a, found_b
);
  import pdt_pkg::*;

  logic full;
  logic push;
  cmd_t push_cmd;
  logic cmd_valid;
  cmd_t head_cmd;
  logic pop;

  pdt_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .smp_a_i   (s_axis_tdata[SAMPLE_BITS-1:0]),
    .smp_b_i   (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .full_i    (full),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  pdt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .valid_o (cmd_valid),
    .cmd_o   (head_cmd),
    .pop_i   (pop)
  );

  pdt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_user_o    (m_axis_tuser)
  );

endmodule

// File: hw/rtl/pdt_front.sv
// Front end: record position counter and request classification.
// Depends on pdt_pkg; feeds the command queue.
module pdt_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_valid_i,
  output logic                            s_ready_o,
  input  logic [pdt_pkg::SAMPLE_BITS-1:0] smp_a_i,
  input  logic [pdt_pkg::SAMPLE_BITS-1:0] smp_b_i,
  input  logic                            full_i,
  output logic                            push_o,
  output pdt_pkg::cmd_t                   cmd_o
);
  import pdt_pkg::*;

  logic [IDX_W-1:0] idx_q, idx_d;
  logic             early;
  logic             last;

  assign early     = 32'(idx_q) < BASELINE_LEN;
  assign last      = 32'(idx_q) == RECORD_LEN - 1;
  assign s_ready_o = !full_i;
  assign push_o    = s_valid_i && !full_i;

  always_comb begin
    cmd_o.kind  = early ? CMD_EARLY : CMD_LIVE;
    cmd_o.scan  = early && (32'(idx_q) == BASELINE_LEN - 1 || last);
    cmd_o.last  = last;
    cmd_o.idx   = idx_q;
    cmd_o.smp_a = smp_a_i;
    cmd_o.smp_b = smp_b_i;
  end

  always_comb begin
    idx_d = idx_q;
    if (push_o) begin
      idx_d = last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// File: hw/rtl/pdt_fifo.sv
// Short command queue between front end and back end.
// Depends on pdt_pkg for the command type and depth.
module pdt_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pdt_pkg::cmd_t cmd_i,
  output logic          full_o,
  output logic          valid_o,
  output pdt_pkg::cmd_t cmd_o,
  input  logic          pop_i
);
  import pdt_pkg::*;

  cmd_t               slot_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == (FIFO_AW + 1)'(FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (FIFO_AW + 1)'(push_i) - (FIFO_AW + 1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: hw/rtl/pdt_back.sv
// Back end: baseline sums, early sample store and scan, edge tests, result register.
// Depends on pdt_pkg; drains the command queue.
module pdt_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pdt_pkg::THR_W-1:0]      cfg_wdata_i,
  input  logic                           cmd_valid_i,
  input  pdt_pkg::cmd_t                  cmd_i,
  output logic                           pop_o,
  output logic                           m_valid_o,
  input  logic                           m_ready_i,
  output logic [pdt_pkg::OUT_DATA_W-1:0] m_data_o,
  output logic [pdt_pkg::OUT_USER_W-1:0] m_user_o
);
  import pdt_pkg::*;

  back_state_e state_q, state_d;

  logic [THR_W-1:0]       thr_q;
  logic [SUM_W-1:0]       sum_a_q, sum_a_d, sum_b_q, sum_b_d;
  logic [1:0]             seen_q, seen_d;
  logic [TIME_W-1:0]      time_a_q, time_a_d, time_b_q, time_b_d;
  logic [PTR_W-1:0]       ptr_q, ptr_d;
  logic [PTR_W-1:0]       last_idx_q, last_idx_d;
  logic                   end_pend_q, end_pend_d;
  logic                   chk_vld_q, chk_vld_d;
  logic [PTR_W-1:0]       chk_idx_q, chk_idx_d;
  logic                   out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0]  out_data_q, out_data_d;
  logic [OUT_USER_W-1:0]  out_user_q, out_user_d;

  logic [SAMPLE_BITS-1:0] mem_a [BASELINE_LEN];
  logic [SAMPLE_BITS-1:0] mem_b [BASELINE_LEN];
  logic [SAMPLE_BITS-1:0] rd_a_q, rd_b_q;

  logic                   mem_we;
  logic                   issue;
  logic                   emit_go;
  logic                   live_tst;
  logic                   tst_en;
  logic [SAMPLE_BITS-1:0] tst_a, tst_b;
  logic [IDX_W-1:0]       tst_idx;
  logic                   hit_a, hit_b;
  logic [TIME_W-1:0]      diff;

  assign pop_o   = state_q == BK_RUN && cmd_valid_i;
  assign mem_we  = pop_o && cmd_i.kind == CMD_EARLY;
  assign issue   = state_q == BK_SCAN && ptr_q <= last_idx_q;
  assign emit_go = state_q == BK_EMIT && (!out_valid_q || m_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_RUN: begin
        if (pop_o) begin
          if (cmd_i.kind == CMD_EARLY && cmd_i.scan) begin
            state_d = BK_SCAN;
          end else if (cmd_i.last) begin
            state_d = BK_EMIT;
          end
        end
      end
      BK_SCAN: begin
        if (!issue && !chk_vld_q) begin
          state_d = end_pend_q ? BK_EMIT : BK_RUN;
        end
      end
      BK_EMIT: begin
        if (emit_go) begin
          state_d = BK_RUN;
        end
      end
      default: state_d = BK_RUN;
    endcase
  end

  always_comb begin
    live_tst = pop_o && cmd_i.kind == CMD_LIVE;
    tst_en   = live_tst || chk_vld_q;
    tst_a    = live_tst ? cmd_i.smp_a : rd_a_q;
    tst_b    = live_tst ? cmd_i.smp_b : rd_b_q;
    tst_idx  = live_tst ? cmd_i.idx : IDX_W'(chk_idx_q);
    hit_a    = tst_en && !seen_q[0] && crosses(sum_a_q, tst_a, thr_q);
    hit_b    = tst_en && !seen_q[1] && crosses(sum_b_q, tst_b, thr_q);
    diff     = (time_b_q >= time_a_q) ? time_b_q - time_a_q : time_a_q - time_b_q;
  end

  always_comb begin
    sum_a_d     = sum_a_q;
    sum_b_d     = sum_b_q;
    seen_d      = seen_q | {hit_b, hit_a};
    time_a_d    = hit_a ? to_time(tst_idx) : time_a_q;
    time_b_d    = hit_b ? to_time(tst_idx) : time_b_q;
    ptr_d       = issue ? ptr_q + 1'b1 : ptr_q;
    last_idx_d  = last_idx_q;
    end_pend_d  = end_pend_q;
    chk_vld_d   = issue;
    chk_idx_d   = ptr_q;
    out_valid_d = m_ready_i ? 1'b0 : out_valid_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    if (mem_we) begin
      sum_a_d = sum_a_q + SUM_W'(cmd_i.smp_a);
      sum_b_d = sum_b_q + SUM_W'(cmd_i.smp_b);
      if (cmd_i.scan) begin
        ptr_d      = PTR_W'(1);
        last_idx_d = cmd_i.idx[PTR_W-1:0];
        end_pend_d = cmd_i.last;
      end
    end
    if (emit_go) begin
      out_valid_d = 1'b1;
      out_data_d  = OUT_DATA_W'({diff, time_b_q, time_a_q});
      out_user_d  = seen_q;
      seen_d      = '0;
      sum_a_d     = '0;
      sum_b_d     = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_a[cmd_i.idx[BL_AW-1:0]] <= cmd_i.smp_a;
      mem_b[cmd_i.idx[BL_AW-1:0]] <= cmd_i.smp_b;
    end
    if (issue) begin
      rd_a_q <= mem_a[ptr_q[BL_AW-1:0]];
      rd_b_q <= mem_b[ptr_q[BL_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_RUN;
      thr_q       <= THR_W'(THR_RESET);
      sum_a_q     <= '0;
      sum_b_q     <= '0;
      seen_q      <= '0;
      time_a_q    <= '0;
      time_b_q    <= '0;
      ptr_q       <= '0;
      last_idx_q  <= '0;
      end_pend_q  <= 1'b0;
      chk_vld_q   <= 1'b0;
      chk_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      sum_a_q     <= sum_a_d;
      sum_b_q     <= sum_b_d;
      seen_q      <= seen_d;
      time_a_q    <= time_a_d;
      time_b_q    <= time_b_d;
      ptr_q       <= ptr_d;
      last_idx_q  <= last_idx_d;
      end_pend_q  <= end_pend_d;
      chk_vld_q   <= chk_vld_d;
      chk_idx_q   <= chk_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;
  assign m_user_o  = out_user_q;

  a_chk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_vld_q |-> (chk_idx_q != '0 && chk_idx_q <= last_idx_q))
    else $error("scan check outside buffered range");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |=> (out_valid_q && seen_q == '0 && sum_a_q == '0 && sum_b_q == '0))
    else $error("record state not cleared on result");

  a_seen_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seen_q[0] && state_q != BK_EMIT) |=> seen_q[0])
    else $error("channel one edge lost within record");

  a_no_pop_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chk_vld_q || issue) |-> !pop_o)
    else $error("queue drained during scan");

endmodule

// File: dv/tb.sv
// Self-checking bench for dual_channel_pulse_time_difference_core: whole records are
// streamed in and each result is checked against a bit-true tracker or, for a typed
// directed row, against that row's expected values. Depends on pdt_pkg and the core RTL.
module tb;
  import pdt_pkg::*;

  localparam int RANDOM_RECORDS = 26;
  localparam int SETTLE_CYCLES  = BASELINE_LEN + 10;
  localparam int DRAIN_CYCLES   = BASELINE_LEN + 20;
  localparam int IDLE_LIMIT     = 20000;

  typedef struct packed {
    logic [TIME_W-1:0] time_a;
    logic [TIME_W-1:0] time_b;
    logic [TIME_W-1:0] time_diff;
    logic              found_a;
    logic              found_b;
  } edge_result_t;

  typedef struct packed {
    int thr;
    int base_a;
    int start_a;
    int depth_a;
    int base_b;
    int start_b;
    int depth_b;
    int width;
    int noise;
    bit scramble;
    bit typed;
    int exp_a;
    int exp_b;
    int exp_d;
    bit exp_fa;
    bit exp_fb;
  } record_shape_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [THR_W-1:0]       cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic [OUT_USER_W-1:0]  m_axis_tuser;

  dual_channel_pulse_time_difference_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // discriminator tracker state
  int                     thr_now;
  int                     pos_q;
  int                     sum_a;
  int                     sum_b;
  logic [SAMPLE_BITS-1:0] early_a [BASELINE_LEN];
  logic [SAMPLE_BITS-1:0] early_b [BASELINE_LEN];
  logic [TIME_W-1:0]      edge_a_q;
  logic [TIME_W-1:0]      edge_b_q;
  bit                     seen_a;
  bit                     seen_b;

  edge_result_t           record_results_due [$];
  edge_result_t           want_res;
  edge_result_t           seen_res;
  int                     mismatches;
  int                     idle_cycles;
  int                     burst_left;
  int                     stall_left;

  function automatic bit crosses_thr(int sum, logic [SAMPLE_BITS-1:0] smp);
    return longint'(sum) - longint'(BASELINE_LEN) * longint'(smp) >
           longint'(BASELINE_LEN) * longint'(thr_now);
  endfunction

  function automatic void mark_edge(bit chan, int idx);
    if (!chan) begin
      edge_a_q = TIME_W'(idx * 4);
      seen_a   = 1'b1;
    end else begin
      edge_b_q = TIME_W'(idx * 4);
      seen_b   = 1'b1;
    end
  endfunction

  function automatic void scan_early_store(int last);
    for (int i = 1; i <= last && i < BASELINE_LEN; i++) begin
      if (!seen_a && crosses_thr(sum_a, early_a[i])) mark_edge(1'b0, i);
      if (!seen_b && crosses_thr(sum_b, early_b[i])) mark_edge(1'b1, i);
    end
  endfunction

  function automatic bit advance_discriminator(input logic [SAMPLE_BITS-1:0] a,
                                               input logic [SAMPLE_BITS-1:0] b,
                                               output edge_result_t res);
    int i;
    i   = pos_q;
    res = '0;
    if (i < BASELINE_LEN) begin
      early_a[i] = a;
      early_b[i] = b;
      sum_a += int'(a);
      sum_b += int'(b);
      if (i == BASELINE_LEN - 1) scan_early_store(i);
    end else begin
      if (!seen_a && crosses_thr(sum_a, a)) mark_edge(1'b0, i);
      if (!seen_b && crosses_thr(sum_b, b)) mark_edge(1'b1, i);
    end
    if (i + 1 < RECORD_LEN) begin
      pos_q = i + 1;
      return 1'b0;
    end
    if (i + 1 < BASELINE_LEN) scan_early_store(i);
    res.time_a    = edge_a_q;
    res.time_b    = edge_b_q;
    res.time_diff = (edge_b_q >= edge_a_q) ? edge_b_q - edge_a_q : edge_a_q - edge_b_q;
    res.found_a   = seen_a;
    res.found_b   = seen_b;
    pos_q  = 0;
    sum_a  = 0;
    sum_b  = 0;
    seen_a = 1'b0;
    seen_b = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] shape_sample(int base, int start, int depth,
                                                          int width, int noise, int k,
                                                          bit scramble);
    int v;
    if (scramble) return SAMPLE_BITS'($urandom);
    v = base;
    if (k >= start && k < start + width) v -= depth;
    if (noise > 0) v += int'($urandom_range(2 * noise)) - noise;
    if (v < 0) v = 0;
    if (v > (1 << SAMPLE_BITS) - 1) v = (1 << SAMPLE_BITS) - 1;
    return SAMPLE_BITS'(v);
  endfunction

  task automatic run_record(record_shape_t r);
    logic [SAMPLE_BITS-1:0] sa;
    logic [SAMPLE_BITS-1:0] sb;
    edge_result_t           res;
    if (r.thr != thr_now) begin
      // hold the stream until the core has drained
      s_axis_tvalid <= 1'b0;
      while (record_results_due.size() != 0) @(posedge clk_i);
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      cfg_wdata_i <= THR_W'(r.thr);
      cfg_we_i    <= 1'b1;
      @(posedge clk_i);
      cfg_we_i    <= 1'b0;
      thr_now = r.thr;
    end
    for (int k = 0; k < RECORD_LEN; k++) begin
      sa = shape_sample(r.base_a, r.start_a, r.depth_a, r.width, r.noise, k, r.scramble);
      sb = shape_sample(r.base_b, r.start_b, r.depth_b, r.width, r.noise, k, r.scramble);
      if (burst_left == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        burst_left = ($urandom_range(3) == 0) ? $urandom_range(500, 3000)
                                              : $urandom_range(1, 80);
      end
      burst_left--;
      s_axis_tdata  <= IN_DATA_W'({sb, sa});
      s_axis_tvalid <= 1'b1;
      do @(posedge clk_i); while (!s_axis_tready);
      if (advance_discriminator(sa, sb, res)) begin
        if (r.typed) begin
          res.time_a    = TIME_W'(r.exp_a);
          res.time_b    = TIME_W'(r.exp_b);
          res.time_diff = TIME_W'(r.exp_d);
          res.found_a   = r.exp_fa;
          res.found_b   = r.exp_fb;
        end
        record_results_due.push_back(res);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_left <= 0;
    end else if (stall_left == 0) begin
      m_axis_tready <= ~m_axis_tready;
      if (m_axis_tready) begin
        stall_left <= $urandom_range(1, 40);
      end else begin
        stall_left <= ($urandom_range(3) == 0) ? $urandom_range(200, 2000)
                                               : $urandom_range(1, 60);
      end
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_res.time_a    = m_axis_tdata[TIME_W-1:0];
      seen_res.time_b    = m_axis_tdata[2*TIME_W-1:TIME_W];
      seen_res.time_diff = m_axis_tdata[3*TIME_W-1:2*TIME_W];
      seen_res.found_a   = m_axis_tuser[0];
      seen_res.found_b   = m_axis_tuser[1];
      if (record_results_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: a=%0d b=%0d diff=%0d found=%b%b",
                   seen_res.time_a, seen_res.time_b, seen_res.time_diff,
                   seen_res.found_a, seen_res.found_b);
        mismatches++;
      end else begin
        want_res = record_results_due.pop_front();
        if (seen_res != want_res) begin
          if (mismatches < 10)
            $display("mismatch: expected a=%0d b=%0d diff=%0d found=%b%b, got a=%0d b=%0d diff=%0d found=%b%b",
                     want_res.time_a, want_res.time_b, want_res.time_diff,
                     want_res.found_a, want_res.found_b,
                     seen_res.time_a, seen_res.time_b, seen_res.time_diff,
                     seen_res.found_a, seen_res.found_b);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  record_shape_t directed_rows [12];

  initial begin
    record_shape_t rnd;
    int            kind;
    thr_now     = THR_RESET;
    pos_q       = 0;
    sum_a       = 0;
    sum_b       = 0;
    edge_a_q    = '0;
    edge_b_q    = '0;
    seen_a      = 1'b0;
    seen_b      = 1'b0;
    mismatches  = 0;
    idle_cycles = 0;
    burst_left  = 0;
    // thr, base/start/depth a, base/start/depth b, width, noise, scramble, typed, expected
    directed_rows = '{
      '{1200,  8000,    0,     0,  8000,    0,     0,   1,  0, 0, 1,     0,     0,     0, 0, 0},
      '{1200,  8000, 4000,  1201,  8000, 6000,  1200,   8,  0, 0, 1, 16000,     0, 16000, 1, 0},
      '{1200,  8000,    0,     0,  8000, 8191,  2000,   1,  0, 0, 1, 16000, 32764, 16764, 0, 1},
      '{1200, 16383,    0, 16383, 16383,    0, 16383,   1,  0, 0, 1, 16000, 32764, 16764, 0, 0},
      '{   0,  5000,    1,     1,  5000,   99,     1,   1,  0, 0, 1,     4,   396,   392, 1, 1},
      '{16383, 16383, 200, 16383, 16383,    0,     0, 100,  0, 0, 1,     4,   396,   392, 0, 0},
      '{   0,     0,    0,     0, 16383,    0,     0,   1,  0, 0, 1,     4,   396,   392, 0, 0},
      '{1200, 10000,  100,  5000, 10000,  100,  5000,   4,  0, 0, 1,   400,   400,     0, 1, 1},
      '{16382, 16383, 500, 16383, 16383,    0,     0,   1,  0, 0, 1,  2000,   400,  1600, 1, 0},
      '{ 700,  9000,   30,  1500,  7000, 2500,   900,  50, 40, 0, 0,     0,     0,     0, 0, 0},
      '{1200,     0,    0,     0,     0,    0,     0,   1,  0, 1, 0,     0,     0,     0, 0, 0},
      '{3000, 12000, 7000,  6000, 12000, 1500,  6000,  20,  0, 0, 1, 28000,  6000, 22000, 1, 1}
    };
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[n]) run_record(directed_rows[n]);

    for (int n = 0; n < RANDOM_RECORDS; n++) begin
      rnd = '0;
      rnd.thr = thr_now;
      if ($urandom_range(1) == 0) begin
        case ($urandom_range(9))
          0:       rnd.thr = 0;
          1:       rnd.thr = (1 << THR_W) - 1;
          2, 3:    rnd.thr = $urandom_range((1 << THR_W) - 1);
          default: rnd.thr = $urandom_range(200, 3000);
        endcase
      end
      kind      = $urandom_range(9);
      rnd.width = $urandom_range(1, 300);
      rnd.noise = $urandom_range(0, 60);
      rnd.base_a = $urandom_range(2000, (1 << SAMPLE_BITS) - 1);
      rnd.base_b = $urandom_range(2000, (1 << SAMPLE_BITS) - 1);
      if (kind < 2) begin
        rnd.scramble = 1'b1;
      end else if (kind > 2) begin
        case ($urandom_range(5))
          0:       rnd.start_a = $urandom_range(1, BASELINE_LEN - 1);
          1:       rnd.start_a = 0;
          2:       rnd.start_a = RECORD_LEN - 1;
          default: rnd.start_a = $urandom_range(BASELINE_LEN, RECORD_LEN - 1);
        endcase
        case ($urandom_range(5))
          0:       rnd.start_b = $urandom_range(1, BASELINE_LEN - 1);
          1:       rnd.start_b = 0;
          2:       rnd.start_b = RECORD_LEN - 1;
          default: rnd.start_b = $urandom_range(BASELINE_LEN, RECORD_LEN - 1);
        endcase
        rnd.depth_a = rnd.thr + int'($urandom_range(400)) - 200;
        rnd.depth_b = rnd.thr + int'($urandom_range(400)) - 200;
        if ($urandom_range(7) == 0) rnd.depth_a = $urandom_range((1 << SAMPLE_BITS) - 1);
        if ($urandom_range(7) == 0) rnd.depth_b = $urandom_range((1 << SAMPLE_BITS) - 1);
      end
      run_record(rnd);
    end

    s_axis_tvalid <= 1'b0;
    while (record_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/pdt_pkg.sv
hw/rtl/pdt_front.sv
hw/rtl/pdt_fifo.sv
hw/rtl/pdt_back.sv
hw/rtl/dual_channel_pulse_time_difference_core.sv
dv/tb.sv
